@@ src/ethp_pkg.sv @@
// shared types and constants for the ethernet/ipv4/tcp header parser
// used by ethp_front, ethp_queue, ethp_back and the top level
`default_nettype none

package ethp_pkg;

    // length of the ethernet header ahead of the ipv4 header (14 bytes)
    localparam logic [7:0] ETH_HDR      = 8'd14;
    // smallest legal ipv4 / tcp header, in bytes
    localparam logic [5:0] MIN_HDR      = 6'd20;
    localparam logic [7:0] PROTO_TCP    = 8'd6;
    // offsets of fields inside the fixed ipv4 header and the tcp header
    localparam logic [7:0] OFF_TLEN_HI  = 8'd2;
    localparam logic [7:0] OFF_TLEN_LO  = 8'd3;
    localparam logic [7:0] OFF_PROTO    = 8'd9;
    localparam logic [7:0] OFF_SRC_LO   = 8'd12;
    localparam logic [7:0] OFF_SRC_HI   = 8'd15;
    localparam logic [7:0] OFF_DST_LO   = 8'd16;
    localparam logic [7:0] OFF_DST_HI   = 8'd19;
    localparam logic [7:0] OFF_SPORT_HI = 8'd0;
    localparam logic [7:0] OFF_SPORT_LO = 8'd1;
    localparam logic [7:0] OFF_DPORT_HI = 8'd2;
    localparam logic [7:0] OFF_DPORT_LO = 8'd3;
    localparam logic [7:0] OFF_DOFF     = 8'd12;
    localparam logic [7:0] POS_MAX      = 8'd255;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 160;

    typedef enum logic [2:0] {
        ST_TCP_OK     = 3'd0,
        ST_IP_SHORT   = 3'd1,
        ST_NOT_TCP    = 3'd2,
        ST_TCP_SHORT  = 3'd3,
        ST_TRUNCATED  = 3'd4,
        ST_UNDERFLOW  = 3'd5
    } t_status;

    // raw header capture of one frame, handed from front to back
    typedef struct packed {
        logic [8:0]  frame_len;
        logic [5:0]  ihl_bytes;
        logic [15:0] total_length;
        logic [7:0]  protocol;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [5:0]  tcp_bytes;
        logic [15:0] packet_number;
    } t_frame_rec;

    // summary word as it leaves the block
    typedef struct packed {
        logic [15:0] payload_bytes;
        logic [7:0]  payload_offset;
        logic [5:0]  tcp_header_bytes;
        logic [5:0]  ip_header_bytes;
        logic [15:0] dest_port;
        logic [15:0] source_port;
        logic [31:0] dest_address;
        logic [31:0] source_address;
        logic [7:0]  ip_protocol;
        logic [15:0] packet_number;
        t_status     status;
    } t_summary;

endpackage

`default_nettype wire

@@ src/ethp_front.sv @@
// front end: takes frame bytes, captures header fields by byte position
// and pushes one raw record per frame into the queue; uses ethp_pkg
`default_nettype none

module ethp_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_accept,
    input  wire logic [7:0]          i_byte,
    input  wire logic                i_last,
    output ethp_pkg::t_frame_rec     o_rec,
    output logic                     o_push
);

    logic [7:0]  r_pos, n_pos;
    logic [5:0]  r_ihl, n_ihl;
    logic [15:0] r_tot, n_tot;
    logic [7:0]  r_proto, n_proto;
    logic [31:0] r_src, n_src;
    logic [31:0] r_dst, n_dst;
    logic [15:0] r_sport, n_sport;
    logic [15:0] r_dport, n_dport;
    logic [5:0]  r_tcp, n_tcp;
    logic [15:0] r_pkt;
    logic [7:0]  tcp_base;

    // field capture with the current word folded in
    always_comb begin
        n_ihl   = r_ihl;
        n_tot   = r_tot;
        n_proto = r_proto;
        n_src   = r_src;
        n_dst   = r_dst;
        n_sport = r_sport;
        n_dport = r_dport;
        n_tcp   = r_tcp;
        tcp_base = ethp_pkg::ETH_HDR + {2'b00, r_ihl};
        if (r_pos == ethp_pkg::ETH_HDR) begin
            n_ihl = {i_byte[3:0], 2'b00};
        end
        if (r_pos == ethp_pkg::ETH_HDR + ethp_pkg::OFF_TLEN_HI ||
            r_pos == ethp_pkg::ETH_HDR + ethp_pkg::OFF_TLEN_LO) begin
            n_tot = {r_tot[7:0], i_byte};
        end
        if (r_pos == ethp_pkg::ETH_HDR + ethp_pkg::OFF_PROTO) begin
            n_proto = i_byte;
        end
        if (r_pos >= ethp_pkg::ETH_HDR + ethp_pkg::OFF_SRC_LO &&
            r_pos <= ethp_pkg::ETH_HDR + ethp_pkg::OFF_SRC_HI) begin
            n_src = {r_src[23:0], i_byte};
        end
        if (r_pos >= ethp_pkg::ETH_HDR + ethp_pkg::OFF_DST_LO &&
            r_pos <= ethp_pkg::ETH_HDR + ethp_pkg::OFF_DST_HI) begin
            n_dst = {r_dst[23:0], i_byte};
        end
        // tcp fields only once a usable ihl is known
        if (r_ihl >= ethp_pkg::MIN_HDR) begin
            if (r_pos == tcp_base + ethp_pkg::OFF_SPORT_HI ||
                r_pos == tcp_base + ethp_pkg::OFF_SPORT_LO) begin
                n_sport = {r_sport[7:0], i_byte};
            end
            if (r_pos == tcp_base + ethp_pkg::OFF_DPORT_HI ||
                r_pos == tcp_base + ethp_pkg::OFF_DPORT_LO) begin
                n_dport = {r_dport[7:0], i_byte};
            end
            if (r_pos == tcp_base + ethp_pkg::OFF_DOFF) begin
                n_tcp = {i_byte[7:4], 2'b00};
            end
        end
        n_pos = (r_pos == ethp_pkg::POS_MAX) ? r_pos : r_pos + 8'd1;
    end

    // record handed to the queue on the last word
    always_comb begin
        o_rec.frame_len     = {1'b0, r_pos} + 9'd1;
        o_rec.ihl_bytes     = n_ihl;
        o_rec.total_length  = n_tot;
        o_rec.protocol      = n_proto;
        o_rec.src_addr      = n_src;
        o_rec.dst_addr      = n_dst;
        o_rec.src_port      = n_sport;
        o_rec.dst_port      = n_dport;
        o_rec.tcp_bytes     = n_tcp;
        o_rec.packet_number = r_pkt;
    end

    assign o_push = i_accept && i_last;

    // per-frame state, cleared after each last word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_ihl   <= '0;
            r_tot   <= '0;
            r_proto <= '0;
            r_src   <= '0;
            r_dst   <= '0;
            r_sport <= '0;
            r_dport <= '0;
            r_tcp   <= '0;
            r_pkt   <= 16'd1;
        end else if (i_accept) begin
            if (i_last) begin
                r_pos   <= '0;
                r_ihl   <= '0;
                r_tot   <= '0;
                r_proto <= '0;
                r_src   <= '0;
                r_dst   <= '0;
                r_sport <= '0;
                r_dport <= '0;
                r_tcp   <= '0;
                r_pkt   <= r_pkt + 16'd1;
            end else begin
                r_pos   <= n_pos;
                r_ihl   <= n_ihl;
                r_tot   <= n_tot;
                r_proto <= n_proto;
                r_src   <= n_src;
                r_dst   <= n_dst;
                r_sport <= n_sport;
                r_dport <= n_dport;
                r_tcp   <= n_tcp;
            end
        end
    end

    // a frame end always leaves the capture state clear
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last) |=> (r_pos == 8'd0 && r_ihl == 6'd0 && r_tcp == 6'd0))
        else $error("capture state not cleared after frame end");

endmodule

`default_nettype wire

@@ src/ethp_queue.sv @@
// short record queue between the front and back ends
// depth from ethp_pkg::QUEUE_DEPTH; holds ethp_pkg::t_frame_rec
`default_nettype none

module ethp_queue (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire ethp_pkg::t_frame_rec i_rec,
    input  wire logic                i_pop,
    output ethp_pkg::t_frame_rec     o_rec,
    output logic                     o_empty,
    output logic                     o_full
);

    ethp_pkg::t_frame_rec r_mem [ethp_pkg::QUEUE_DEPTH];
    logic [ethp_pkg::QPTR_W-1:0] r_wr, r_rd;
    logic [ethp_pkg::QCNT_W-1:0] r_cnt;
    logic do_push, do_pop;

    localparam logic [ethp_pkg::QPTR_W-1:0] PTR_LAST =
        ethp_pkg::QPTR_W'(ethp_pkg::QUEUE_DEPTH - 1);
    localparam logic [ethp_pkg::QCNT_W-1:0] CNT_FULL =
        ethp_pkg::QCNT_W'(ethp_pkg::QUEUE_DEPTH);

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNT_FULL);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rec   = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // the front must never push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("record pushed into full queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_FULL)
        else $error("queue fill count out of range");

endmodule

`default_nettype wire

@@ src/ethp_back.sv @@
// back end: classifies a captured frame record and holds the summary word
// in an output register; uses ethp_pkg types and constants
`default_nettype none

module ethp_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire ethp_pkg::t_frame_rec i_rec,
    input  wire logic                i_empty,
    output logic                     o_pop,
    output ethp_pkg::t_summary       o_sum,
    output logic                     o_valid,
    input  wire logic                i_ready
);

    ethp_pkg::t_summary r_sum, n_sum;
    logic               r_valid;
    logic [8:0]         tcp_base;
    logic [6:0]         hdrs;

    // status by check order, first failing check wins
    always_comb begin
        tcp_base = 9'(ethp_pkg::ETH_HDR) + {3'b000, i_rec.ihl_bytes};
        hdrs     = {1'b0, i_rec.ihl_bytes} + {1'b0, i_rec.tcp_bytes};
        n_sum.packet_number    = i_rec.packet_number;
        n_sum.ip_protocol      = i_rec.protocol;
        n_sum.source_address   = i_rec.src_addr;
        n_sum.dest_address     = i_rec.dst_addr;
        n_sum.ip_header_bytes  = i_rec.ihl_bytes;
        n_sum.source_port      = '0;
        n_sum.dest_port        = '0;
        n_sum.tcp_header_bytes = '0;
        n_sum.payload_offset   = '0;
        n_sum.payload_bytes    = '0;
        if (i_rec.frame_len < 9'(ethp_pkg::ETH_HDR) + 9'd1) begin
            n_sum.status = ethp_pkg::ST_TRUNCATED;
        end else if (i_rec.ihl_bytes < ethp_pkg::MIN_HDR) begin
            n_sum.status = ethp_pkg::ST_IP_SHORT;
        end else if (i_rec.frame_len <
                     9'(ethp_pkg::ETH_HDR) + 9'(ethp_pkg::MIN_HDR)) begin
            n_sum.status = ethp_pkg::ST_TRUNCATED;
        end else if (i_rec.protocol != ethp_pkg::PROTO_TCP) begin
            n_sum.status = ethp_pkg::ST_NOT_TCP;
        end else if (i_rec.frame_len < tcp_base + 9'(ethp_pkg::OFF_DOFF) + 9'd1) begin
            n_sum.status = ethp_pkg::ST_TRUNCATED;
        end else if (i_rec.tcp_bytes < ethp_pkg::MIN_HDR) begin
            n_sum.status           = ethp_pkg::ST_TCP_SHORT;
            n_sum.tcp_header_bytes = i_rec.tcp_bytes;
        end else if (i_rec.frame_len < tcp_base + {3'b000, i_rec.tcp_bytes}) begin
            n_sum.status = ethp_pkg::ST_TRUNCATED;
        end else begin
            n_sum.source_port      = i_rec.src_port;
            n_sum.dest_port        = i_rec.dst_port;
            n_sum.tcp_header_bytes = i_rec.tcp_bytes;
            n_sum.payload_offset   = ethp_pkg::ETH_HDR + {1'b0, hdrs};
            if (i_rec.total_length < {9'd0, hdrs}) begin
                n_sum.status = ethp_pkg::ST_UNDERFLOW;
            end else begin
                n_sum.status        = ethp_pkg::ST_TCP_OK;
                n_sum.payload_bytes = i_rec.total_length - {9'd0, hdrs};
            end
        end
    end

    // take the queue head whenever the output register is free
    assign o_pop   = !i_empty && (!r_valid || i_ready);
    assign o_sum   = r_sum;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_sum <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // ports only carry values when the tcp header was complete
    a_ports_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_sum.status != ethp_pkg::ST_TCP_OK &&
         r_sum.status != ethp_pkg::ST_UNDERFLOW) |->
        (r_sum.source_port == 16'd0 && r_sum.dest_port == 16'd0 &&
         r_sum.payload_offset == 8'd0))
        else $error("ports or offset set on a failed frame");

    // payload offset agrees with the two header sizes
    a_offset_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_sum.status == ethp_pkg::ST_TCP_OK) |->
        (r_sum.payload_offset == ethp_pkg::ETH_HDR + {2'b00, r_sum.ip_header_bytes}
                                 + {2'b00, r_sum.tcp_header_bytes}))
        else $error("payload offset does not match header sizes");

endmodule

`default_nettype wire

@@ src/eth_ipv4_tcp_header_parser_unit.sv @@
// Ethernet/IPv4/TCP header parser. Frame bytes come in one word per clock on
// the slave stream, last byte marked by tlast; the block accepts a byte every
// cycle that tready is high. For each frame it emits one summary word, valid
// once its record has passed the queue and the output register, and handed over
// at the next edge where the master side is ready. The front end captures header
// fields by byte position, a two-entry record queue lets the summary side
// stall on its own, and the back end classifies and registers the summary.
// The slave side only holds off (tready low) while both queue entries wait.
// top level: ties ethp_front, ethp_queue and ethp_back; uses ethp_pkg
`default_nettype none

module eth_ipv4_tcp_header_parser_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // slave stream
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    input  wire logic [ethp_pkg::IN_TDATA_W-1:0]     i_s_tdata,  // [7:0] frame_byte
    input  wire logic                                i_s_tlast,  // last_byte
    // master stream
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    // [2:0] status, [18:3] packet_number, [26:19] ip_protocol,
    // [58:27] source_address, [90:59] dest_address, [106:91] source_port,
    // [122:107] dest_port, [128:123] ip_header_bytes,
    // [134:129] tcp_header_bytes, [142:135] payload_offset,
    // [158:143] payload_bytes, [159] zero
    output logic [ethp_pkg::OUT_TDATA_W-1:0]         o_m_tdata
);

    ethp_pkg::t_frame_rec push_rec, head_rec;
    ethp_pkg::t_summary   sum;
    logic                 accept, push, pop, q_empty, q_full;

    assign o_s_tready = !q_full;
    assign accept     = i_s_tvalid && o_s_tready;

    // front end
    ethp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_s_tdata[7:0]),
        .i_last   (i_s_tlast),
        .o_rec    (push_rec),
        .o_push   (push)
    );

    // record queue
    ethp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .i_pop   (pop),
        .o_rec   (head_rec),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // back end
    ethp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rec   (head_rec),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_sum   (sum),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready)
    );

    // summary word packing, status lowest, zero pad bit on top
    assign o_m_tdata = {1'b0, sum};

endmodule

`default_nettype wire

@@ tb/eth_ipv4_tcp_header_parser_unit_tb.sv @@
// testbench for eth_ipv4_tcp_header_parser_unit: frames go in one byte per word,
// and the per-frame summaries are checked field by field against a local parser
// depends on ethp_pkg and the top-level rtl only
`timescale 1ns / 1ps

module eth_ipv4_tcp_header_parser_unit_tb;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int TARGET_BYTES  = 1650;
    localparam int MIN_FRAMES    = 6;
    localparam int DRAIN_FRAME   = 3;
    localparam int IDLE_PCT      = 9;
    localparam int RX_HOLD_AT    = 8;
    localparam int RX_HOLD_LEN   = 400;
    localparam int TAIL_CYCLES   = 20;

    // how the ipv4 total length field of a built frame is chosen
    typedef enum int {
        TLEN_EXACT,
        TLEN_SHORT,
        TLEN_RANDOM,
        TLEN_MAX
    } t_tlen_mode;

    // one input word plus a flag to wait for all summaries before sending it
    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         drain_first;
    } t_wire_byte;

    logic                              i_clk      = 1'b0;
    logic                              i_rst_n    = 1'b0;
    logic                              i_s_tvalid = 1'b0;
    logic                              o_s_tready;
    logic [ethp_pkg::IN_TDATA_W-1:0]   i_s_tdata  = '0;  // [7:0] frame_byte
    logic                              i_s_tlast  = 1'b0; // last_byte
    logic                              o_m_tvalid;
    logic                              i_m_tready = 1'b0;
    // [2:0] status ... [158:143] payload_bytes, [159] zero
    logic [ethp_pkg::OUT_TDATA_W-1:0]  o_m_tdata;

    eth_ipv4_tcp_header_parser_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    t_wire_byte          frame_bytes_q[$];
    logic [7:0]          frame_buf[$];
    ethp_pkg::t_summary  pending_summaries[$];

    // local copy of the parser state
    logic [7:0]  cap_pos      = '0;
    logic [5:0]  cap_ihl      = '0;
    logic [15:0] cap_tlen     = '0;
    logic [7:0]  cap_proto    = '0;
    logic [31:0] cap_src      = '0;
    logic [31:0] cap_dst      = '0;
    logic [15:0] cap_sport    = '0;
    logic [15:0] cap_dport    = '0;
    logic [5:0]  cap_tcp      = '0;
    logic [15:0] frame_count  = 16'd1;

    int          mismatches   = 0;
    int          bytes_taken  = 0;
    int          results_seen = 0;
    int          cycle_count  = 0;
    int          rx_hold_left = 0;
    bit          rx_hold_done = 1'b0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // clear per-frame capture
    task automatic clear_capture();
        cap_pos   = '0;
        cap_ihl   = '0;
        cap_tlen  = '0;
        cap_proto = '0;
        cap_src   = '0;
        cap_dst   = '0;
        cap_sport = '0;
        cap_dport = '0;
        cap_tcp   = '0;
    endtask

    // capture one accepted byte; on the last byte classify and queue the summary
    task automatic parse_frame_byte(input logic [7:0] b, input logic last);
        int unsigned        p;
        int unsigned        e;
        int unsigned        t;
        int unsigned        flen;
        int unsigned        hdrs;
        ethp_pkg::t_summary s;
        p = cap_pos;
        e = ethp_pkg::ETH_HDR;
        if (p == e) cap_ihl = {b[3:0], 2'b00};
        if (p == e + ethp_pkg::OFF_TLEN_HI || p == e + ethp_pkg::OFF_TLEN_LO)
            cap_tlen = {cap_tlen[7:0], b};
        if (p == e + ethp_pkg::OFF_PROTO) cap_proto = b;
        if (p >= e + ethp_pkg::OFF_SRC_LO && p <= e + ethp_pkg::OFF_SRC_HI)
            cap_src = {cap_src[23:0], b};
        if (p >= e + ethp_pkg::OFF_DST_LO && p <= e + ethp_pkg::OFF_DST_HI)
            cap_dst = {cap_dst[23:0], b};
        // tcp fields sit behind the ip header, only once its length is sane
        if (cap_ihl >= ethp_pkg::MIN_HDR) begin
            t = e + cap_ihl;
            if (p == t + ethp_pkg::OFF_SPORT_HI || p == t + ethp_pkg::OFF_SPORT_LO)
                cap_sport = {cap_sport[7:0], b};
            if (p == t + ethp_pkg::OFF_DPORT_HI || p == t + ethp_pkg::OFF_DPORT_LO)
                cap_dport = {cap_dport[7:0], b};
            if (p == t + ethp_pkg::OFF_DOFF) cap_tcp = {b[7:4], 2'b00};
        end
        if (!last) begin
            if (cap_pos != ethp_pkg::POS_MAX) cap_pos = cap_pos + 8'd1;
        end else begin
            s = '0;
            s.packet_number   = frame_count;
            s.ip_protocol     = cap_proto;
            s.source_address  = cap_src;
            s.dest_address    = cap_dst;
            s.ip_header_bytes = cap_ihl;
            flen = p + 1;
            t = e + cap_ihl;
            // checks in priority order, truncation interleaved
            if (flen < e + 1)
                s.status = ethp_pkg::ST_TRUNCATED;
            else if (cap_ihl < ethp_pkg::MIN_HDR)
                s.status = ethp_pkg::ST_IP_SHORT;
            else if (flen < e + ethp_pkg::MIN_HDR)
                s.status = ethp_pkg::ST_TRUNCATED;
            else if (cap_proto != ethp_pkg::PROTO_TCP)
                s.status = ethp_pkg::ST_NOT_TCP;
            else if (flen < t + ethp_pkg::OFF_DOFF + 1)
                s.status = ethp_pkg::ST_TRUNCATED;
            else if (cap_tcp < ethp_pkg::MIN_HDR) begin
                s.status = ethp_pkg::ST_TCP_SHORT;
                s.tcp_header_bytes = cap_tcp;
            end else if (flen < t + cap_tcp)
                s.status = ethp_pkg::ST_TRUNCATED;
            else begin
                hdrs = cap_ihl + cap_tcp;
                s.source_port      = cap_sport;
                s.dest_port        = cap_dport;
                s.tcp_header_bytes = cap_tcp;
                s.payload_offset   = 8'(e + hdrs);
                if (cap_tlen < hdrs)
                    s.status = ethp_pkg::ST_UNDERFLOW;
                else begin
                    s.status = ethp_pkg::ST_TCP_OK;
                    s.payload_bytes = 16'(cap_tlen - hdrs);
                end
            end
            pending_summaries.push_back(s);
            frame_count = frame_count + 16'd1;
            clear_capture();
        end
    endtask

    // move the frame under construction into the send queue
    task automatic queue_frame(input bit drain_first);
        t_wire_byte w;
        for (int i = 0; i < frame_buf.size(); i++) begin
            w.data = frame_buf[i];
            w.last = (i == frame_buf.size() - 1);
            w.drain_first = drain_first && (i == 0);
            frame_bytes_q.push_back(w);
        end
    endtask

    // raw frame, constant fill or random when fill is negative
    task automatic build_raw_frame(input int len, input int fill, input bit drain_first);
        frame_buf.delete();
        repeat (len) frame_buf.push_back(fill < 0 ? 8'($urandom_range(0, 255)) : 8'(fill));
        queue_frame(drain_first);
    endtask

    // ethernet + ipv4 + tcp frame; headers below 20 bytes still take 20 bytes
    task automatic build_tcp_frame(input int ihl_w, input int doff_w, input int pay_len,
                                   input logic [7:0] proto, input t_tlen_mode tmode,
                                   input int cut, input bit drain_first);
        int          ip_len;
        int          tcp_len;
        int          hdrs;
        logic [15:0] tlen;
        ip_len  = (ihl_w < 5) ? 20 : ihl_w * 4;
        tcp_len = (doff_w < 5) ? 20 : doff_w * 4;
        hdrs    = ihl_w * 4 + doff_w * 4;
        case (tmode)
            TLEN_EXACT:  tlen = 16'(hdrs + pay_len);
            TLEN_SHORT:  tlen = (hdrs > 0) ? 16'($urandom_range(0, hdrs - 1)) : 16'd0;
            TLEN_RANDOM: tlen = 16'($urandom);
            default:     tlen = 16'hFFFF;
        endcase
        frame_buf.delete();
        repeat (ethp_pkg::ETH_HDR) frame_buf.push_back(8'($urandom_range(0, 255)));
        for (int i = 0; i < ip_len; i++) begin
            if (i == 0)
                frame_buf.push_back({4'($urandom_range(0, 15)), 4'(ihl_w)});
            else if (i == ethp_pkg::OFF_TLEN_HI)
                frame_buf.push_back(tlen[15:8]);
            else if (i == ethp_pkg::OFF_TLEN_LO)
                frame_buf.push_back(tlen[7:0]);
            else if (i == ethp_pkg::OFF_PROTO)
                frame_buf.push_back(proto);
            else
                frame_buf.push_back(8'($urandom_range(0, 255)));
        end
        for (int i = 0; i < tcp_len; i++) begin
            if (i == ethp_pkg::OFF_DOFF)
                frame_buf.push_back({4'(doff_w), 4'($urandom_range(0, 15))});
            else
                frame_buf.push_back(8'($urandom_range(0, 255)));
        end
        repeat (pay_len) frame_buf.push_back(8'($urandom_range(0, 255)));
        if (cut > 0)
            while (frame_buf.size() > cut) void'(frame_buf.pop_back());
        queue_frame(drain_first);
    endtask

    function automatic int header_words();
        return ($urandom_range(0, 9) < 7) ? 5 : $urandom_range(5, 15);
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("mismatch at summary %0d: %s got %0h expected %0h",
                 results_seen, field, got, exp_val);
        mismatches++;
    endtask

    task automatic check_field(input string field, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val) report_mismatch(field, got, exp_val);
    endtask

    // compare one summary word with the oldest expected one
    task automatic check_summary(input logic [ethp_pkg::OUT_TDATA_W-1:0] word);
        ethp_pkg::t_summary got;
        ethp_pkg::t_summary want;
        got = ethp_pkg::t_summary'(word[$bits(ethp_pkg::t_summary)-1:0]);
        if (pending_summaries.size() == 0) begin
            report_mismatch("unexpected word", word[31:0], 32'd0);
        end else begin
            want = pending_summaries.pop_front();
            check_field("status", 32'(got.status), 32'(want.status));
            check_field("packet_number", 32'(got.packet_number), 32'(want.packet_number));
            check_field("ip_protocol", 32'(got.ip_protocol), 32'(want.ip_protocol));
            check_field("source_address", got.source_address, want.source_address);
            check_field("dest_address", got.dest_address, want.dest_address);
            check_field("source_port", 32'(got.source_port), 32'(want.source_port));
            check_field("dest_port", 32'(got.dest_port), 32'(want.dest_port));
            check_field("ip_header_bytes", 32'(got.ip_header_bytes),
                        32'(want.ip_header_bytes));
            check_field("tcp_header_bytes", 32'(got.tcp_header_bytes),
                        32'(want.tcp_header_bytes));
            check_field("payload_offset", 32'(got.payload_offset), 32'(want.payload_offset));
            check_field("payload_bytes", 32'(got.payload_bytes), 32'(want.payload_bytes));
            check_field("pad bit", 32'(word[ethp_pkg::OUT_TDATA_W-1]), 32'd0);
        end
        results_seen++;
    endtask

    // byte sender: predicts on each accepted word, then offers the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            clear_capture();
            frame_count = 16'd1;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                parse_frame_byte(i_s_tdata, i_s_tlast);
                bytes_taken++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (frame_bytes_q.size() > 0
                    && !(frame_bytes_q[0].drain_first && pending_summaries.size() > 0)
                    && !((bytes_taken < 600 || bytes_taken >= 1000)
                         && $urandom_range(0, 99) < IDLE_PCT)) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= frame_bytes_q[0].data;
                    i_s_tlast  <= frame_bytes_q[0].last;
                    void'(frame_bytes_q.pop_front());
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // summary receiver with random stalls, one long hold-off and an always-ready stretch
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) check_summary(o_m_tdata);
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                i_m_tready <= 1'b0;
            end else if (results_seen == RX_HOLD_AT && !rx_hold_done) begin
                rx_hold_done = 1'b1;
                rx_hold_left = RX_HOLD_LEN;
                i_m_tready <= 1'b0;
            end else if (results_seen >= 12 && results_seen < 22) begin
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int frames;
        int r;
        int cut;
        logic [7:0] proto;

        // directed frames: extremes and each status path
        build_raw_frame(1, 8'h00, 1'b0);                         // lone byte
        build_raw_frame(14, 8'hFF, 1'b0);                        // ethernet header only
        build_raw_frame(40, 8'h00, 1'b0);                        // ihl of zero
        build_raw_frame(60, 8'hFF, 1'b0);                        // all ones, not tcp
        build_tcp_frame(5, 5, 0, ethp_pkg::PROTO_TCP, TLEN_EXACT, 0, 1'b0);
        build_tcp_frame(15, 15, 8, ethp_pkg::PROTO_TCP, TLEN_EXACT, 0, 1'b0);
        build_tcp_frame(4, 5, 4, ethp_pkg::PROTO_TCP, TLEN_EXACT, 0, 1'b0);
        // ihl byte only
        build_tcp_frame(5, 5, 0, ethp_pkg::PROTO_TCP, TLEN_EXACT, 15, 1'b0);
        // fixed ip cut
        build_tcp_frame(5, 5, 0, ethp_pkg::PROTO_TCP, TLEN_EXACT, 25, 1'b0);
        build_tcp_frame(5, 5, 4, 8'd17, TLEN_EXACT, 0, 1'b0);
        // no data offset
        build_tcp_frame(5, 5, 0, ethp_pkg::PROTO_TCP, TLEN_EXACT, 46, 1'b0);
        build_tcp_frame(5, 0, 0, ethp_pkg::PROTO_TCP, TLEN_EXACT, 0, 1'b0);
        build_tcp_frame(5, 4, 2, ethp_pkg::PROTO_TCP, TLEN_EXACT, 0, 1'b0);
        // tcp options cut
        build_tcp_frame(5, 10, 0, ethp_pkg::PROTO_TCP, TLEN_EXACT, 64, 1'b0);
        build_tcp_frame(5, 5, 10, ethp_pkg::PROTO_TCP, TLEN_SHORT, 0, 1'b0);
        build_tcp_frame(5, 5, 3, ethp_pkg::PROTO_TCP, TLEN_MAX, 0, 1'b0);
        // position saturates
        build_tcp_frame(5, 5, 260, ethp_pkg::PROTO_TCP, TLEN_EXACT, 0, 1'b0);

        // random frames, mostly well formed
        frames = 0;
        while (frame_bytes_q.size() < TARGET_BYTES || frames < MIN_FRAMES) begin
            r = $urandom_range(0, 99);
            proto = ethp_pkg::PROTO_TCP;
            if (r < 60) begin
                r = $urandom_range(0, 9);
                build_tcp_frame(header_words(), header_words(), $urandom_range(0, 24),
                                ethp_pkg::PROTO_TCP,
                                (r < 8) ? TLEN_EXACT : (r < 9) ? TLEN_SHORT : TLEN_RANDOM,
                                0, frames == DRAIN_FRAME);
            end else if (r < 75) begin
                cut = $urandom_range(1, 90);
                build_tcp_frame(header_words(), header_words(), $urandom_range(0, 8),
                                ethp_pkg::PROTO_TCP, TLEN_EXACT, cut,
                                frames == DRAIN_FRAME);
            end else if (r < 82) begin
                build_tcp_frame($urandom_range(0, 4), header_words(), $urandom_range(0, 8),
                                ethp_pkg::PROTO_TCP, TLEN_EXACT, 0, frames == DRAIN_FRAME);
            end else if (r < 88) begin
                proto = 8'($urandom_range(0, 255));
                if (proto == ethp_pkg::PROTO_TCP) proto = 8'd17;
                build_tcp_frame(header_words(), header_words(), $urandom_range(0, 8),
                                proto, TLEN_EXACT, 0, frames == DRAIN_FRAME);
            end else if (r < 93) begin
                build_tcp_frame(header_words(), $urandom_range(0, 4), $urandom_range(0, 8),
                                ethp_pkg::PROTO_TCP, TLEN_RANDOM, 0, frames == DRAIN_FRAME);
            end else if (r < 98) begin
                build_raw_frame($urandom_range(1, 60), -1, frames == DRAIN_FRAME);
            end else begin
                build_tcp_frame(header_words(), header_words(), $urandom_range(220, 280),
                                ethp_pkg::PROTO_TCP, TLEN_EXACT, 0, frames == DRAIN_FRAME);
            end
            frames++;
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (frame_bytes_q.size() > 0 || i_s_tvalid) @(posedge i_clk);
        while (pending_summaries.size() > 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending_summaries.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
